>>> rtl/abst_pkg.sv
// Package for the array binary search tree: sizes, status codes and item types.
`default_nettype none

package abst_pkg;

  localparam int TREE_LEVELS = 10;
  localparam int SLOT_W      = TREE_LEVELS;
  localparam int SLOT_COUNT  = 1 << TREE_LEVELS;
  localparam int KEY_W       = 32;
  localparam int OUT_SLOT_W  = 10;
  localparam int LEVEL_W     = 4;

  localparam logic [1:0] STAT_FOUND     = 2'd0;
  localparam logic [1:0] STAT_INSERTED  = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_NO_ROOM   = 2'd3;

  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [LEVEL_W-1:0]    level;
  } rsp_t;

  // one tree slot as held in the RAM
  typedef struct packed {
    logic                    filled;
    logic signed [KEY_W-1:0] key;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/array_bst_insert_lookup_unit.sv
// Top level of the array binary search tree: walk sequencer, slot RAM and result register.
`default_nettype none

// Lookup/insert on a binary search tree held in one slot RAM (root at slot 1,
// children of slot i at 2i and 2i+1, signed keys). After reset the block clears
// all 1024 slots of the RAM in turn and takes no item meanwhile. An item then
// passes through the idle state, which reads the root, one walk step per tree
// level visited (one RAM read and one key compare each) and the done state,
// which hands over the result; the tree has 10 levels. A new item may be taken
// while the previous result still waits in the output register.

module array_bst_insert_lookup_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire abst_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output abst_pkg::rsp_t     rsp
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [abst_pkg::SLOT_W-1:0]  clr_addr;
  logic [abst_pkg::SLOT_W-1:0]  slot, slot_next;
  logic [abst_pkg::LEVEL_W-1:0] level, level_next;
  logic                         insert;
  logic signed [abst_pkg::KEY_W-1:0] key;
  abst_pkg::rsp_t               res, res_next;

  logic                         ram_we;
  logic [abst_pkg::SLOT_W-1:0]  ram_waddr;
  abst_pkg::entry_t             ram_wdata;
  logic [abst_pkg::SLOT_W-1:0]  ram_raddr;
  logic [$bits(abst_pkg::entry_t)-1:0] ram_rdata;

  abst_pkg::entry_t             here;
  logic                         hit;
  logic                         go_right;
  logic                         last;
  logic [abst_pkg::SLOT_W-1:0]  slot_child;

  abst_ram #(
    .WIDTH ($bits(abst_pkg::entry_t)),
    .DEPTH (abst_pkg::SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign here       = abst_pkg::entry_t'(ram_rdata);
  assign hit        = (here.key == key);
  assign go_right   = (here.key < key);
  assign last       = (level == abst_pkg::LEVEL_W'(abst_pkg::TREE_LEVELS - 1));
  assign slot_child = {slot[abst_pkg::SLOT_W-2:0], go_right};
  assign req_ready  = (state == ST_IDLE);

  always_comb begin
    state_next       = state;
    slot_next        = slot;
    level_next       = level;
    res_next         = res;
    ram_we           = 1'b0;
    ram_waddr        = slot;
    ram_wdata.filled = 1'b1;
    ram_wdata.key    = key;
    ram_raddr        = (state == ST_WALK) ? slot_child : abst_pkg::SLOT_W'(1);

    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_WALK;
          slot_next  = abst_pkg::SLOT_W'(1);
          level_next = '0;
        end
      end
      ST_WALK: begin
        res_next.slot  = abst_pkg::OUT_SLOT_W'(slot);
        res_next.level = level;
        if (!here.filled) begin
          ram_we          = insert;
          res_next.status = insert ? abst_pkg::STAT_INSERTED : abst_pkg::STAT_NOT_FOUND;
          state_next      = ST_DONE;
        end else if (hit) begin
          res_next.status = abst_pkg::STAT_FOUND;
          state_next      = ST_DONE;
        end else if (last) begin
          res_next.status = abst_pkg::STAT_NO_ROOM;
          state_next      = ST_DONE;
        end else begin
          slot_next  = slot_child;
          level_next = level + abst_pkg::LEVEL_W'(1);
        end
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + abst_pkg::SLOT_W'(1);
      end
      if (state == ST_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot  <= slot_next;
    level <= level_next;
    res   <= res_next;
    if (state == ST_IDLE && req_valid) begin
      insert <= req.mode;
      key    <= req.key;
    end
    if (state == ST_DONE && (!rsp_valid || rsp_ready)) begin
      rsp <= res;
    end
  end

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("item taken before slot clear finished");

  a_slot_depth: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> (slot >> level) == abst_pkg::SLOT_W'(1))
    else $error("slot index does not match tree level");

  a_no_room_level: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == abst_pkg::STAT_NO_ROOM
      |-> rsp.level == abst_pkg::LEVEL_W'(abst_pkg::TREE_LEVELS - 1))
    else $error("no-room result below the last level");

endmodule

`default_nettype wire

>>> rtl/abst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module abst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> verif/tb_array_bst_insert_lookup_unit.sv
// Testbench for the array binary search tree: directed and random insert/lookup items.
module tb_array_bst_insert_lookup_unit;

  localparam int RANDOM_ITEMS = 1550;
  localparam int PHASE_LEN    = 525;
  localparam int HOLD_AT      = 1200;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 30;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  localparam logic signed [abst_pkg::KEY_W-1:0] KEY_MIN   = 32'sh8000_0000;
  localparam logic signed [abst_pkg::KEY_W-1:0] KEY_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [abst_pkg::KEY_W-1:0] CHAIN_KEY = 32'sh7FFF_FF00;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  abst_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  abst_pkg::rsp_t rsp;

  array_bst_insert_lookup_unit uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // shadow tree
  logic signed [abst_pkg::KEY_W-1:0] tree_key [abst_pkg::SLOT_COUNT];
  bit tree_filled [abst_pkg::SLOT_COUNT];

  abst_pkg::req_t req_backlog[$];
  abst_pkg::rsp_t rsp_due[$];
  logic signed [abst_pkg::KEY_W-1:0] known_keys[$];

  int sent_count = 0;
  int rsp_count = 0;
  int mismatch_count = 0;
  int stray_count = 0;
  int status_hits [4] = '{0, 0, 0, 0};
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic abst_pkg::rsp_t walk_tree(input abst_pkg::req_t r);
    abst_pkg::rsp_t res;
    int unsigned node;
    int unsigned depth;
    bit done;
    node = 1;
    depth = 0;
    done = 1'b0;
    res = '0;
    while (!done) begin
      if (!tree_filled[node]) begin
        if (r.mode == MODE_INSERT) begin
          tree_key[node] = r.key;
          tree_filled[node] = 1'b1;
          res.status = abst_pkg::STAT_INSERTED;
        end else begin
          res.status = abst_pkg::STAT_NOT_FOUND;
        end
        done = 1'b1;
      end else if (tree_key[node] == r.key) begin
        res.status = abst_pkg::STAT_FOUND;
        done = 1'b1;
      end else if (depth + 1 >= abst_pkg::TREE_LEVELS) begin
        res.status = abst_pkg::STAT_NO_ROOM;
        done = 1'b1;
      end else begin
        node = ($signed(r.key) < $signed(tree_key[node])) ? 2 * node : 2 * node + 1;
        depth++;
      end
    end
    res.slot = node[abst_pkg::OUT_SLOT_W-1:0];
    res.level = depth[abst_pkg::LEVEL_W-1:0];
    return res;
  endfunction

  function automatic int send_idle_pct(input int n);
    if (n < PHASE_LEN) return 19;
    if (n < 2 * PHASE_LEN) return 71;
    return 0;
  endfunction

  function automatic int recv_idle_pct(input int n);
    if (n < PHASE_LEN) return 71;
    if (n < 2 * PHASE_LEN) return 19;
    return 0;
  endfunction

  task automatic add_item(input logic mode, input logic signed [abst_pkg::KEY_W-1:0] key);
    abst_pkg::req_t item;
    item.mode = mode;
    item.key = key;
    req_backlog.push_back(item);
    if (mode == MODE_INSERT) known_keys.push_back(key);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        rsp_due.push_back(walk_tree(req));
        sent_count++;
      end
      if (!req_valid || req_ready) begin
        if (req_backlog.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct(sent_count)) begin
          req <= req_backlog.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    abst_pkg::rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_count++;
        status_hits[rsp.status]++;
        if (rsp_due.size() == 0) begin
          stray_count++;
          if (stray_count + mismatch_count <= 10)
            $display("unexpected result: status %0d slot %0d level %0d",
                     rsp.status, rsp.slot, rsp.level);
        end else begin
          want = rsp_due.pop_front();
          if (rsp.status !== want.status || rsp.slot !== want.slot ||
              rsp.level !== want.level) begin
            mismatch_count++;
            if (stray_count + mismatch_count <= 10)
              $display("result %0d: expected status %0d slot %0d level %0d, got %0d %0d %0d",
                       rsp_count, want.status, want.slot, want.level,
                       rsp.status, rsp.slot, rsp.level);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_ready <= 1'b0;
      end else if (!hold_done && rsp_count == HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct(rsp_count));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, rsp_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic signed [abst_pkg::KEY_W-1:0] k;
    int roll;
    // empty tree, then root 0 and a right-hand chain down to the last level
    add_item(MODE_LOOKUP, 32'sd0);
    add_item(MODE_INSERT, 32'sd0);
    for (int i = 0; i < abst_pkg::TREE_LEVELS - 1; i++)
      add_item(MODE_INSERT, CHAIN_KEY + 16 * i);
    add_item(MODE_INSERT, KEY_MAX);
    add_item(MODE_LOOKUP, KEY_MAX);
    add_item(MODE_INSERT, KEY_MIN);
    add_item(MODE_INSERT, KEY_MIN);
    add_item(MODE_LOOKUP, 32'sd0);
    add_item(MODE_LOOKUP, -32'sd1);
    add_item(MODE_INSERT, -32'sd1);
    add_item(MODE_LOOKUP, CHAIN_KEY + 8);
    add_item(MODE_INSERT, CHAIN_KEY + 8);
    add_item(MODE_INSERT, CHAIN_KEY + 32);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 9))
        0, 1: k = $urandom_range(0, 63) - 32;
        2: begin
          case ($urandom_range(0, 3))
            0: k = KEY_MIN;
            1: k = KEY_MAX;
            2: k = 32'sd0;
            default: k = -32'sd1;
          endcase
        end
        default: k = $urandom;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 60)
        add_item(MODE_INSERT, k);
      else if (roll < 80 && known_keys.size() != 0)
        add_item(MODE_LOOKUP, known_keys[$urandom_range(0, known_keys.size() - 1)]);
      else
        add_item(MODE_LOOKUP, k);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d items sent, %0d results: %0d found, %0d inserted, %0d not found, %0d no room",
             sent_count, rsp_count,
             status_hits[abst_pkg::STAT_FOUND], status_hits[abst_pkg::STAT_INSERTED],
             status_hits[abst_pkg::STAT_NOT_FOUND], status_hits[abst_pkg::STAT_NO_ROOM]);
    $display("%0d mismatches, %0d unexpected results", mismatch_count, stray_count);
    if (mismatch_count == 0 && stray_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/abst_pkg.sv
rtl/abst_ram.sv
rtl/array_bst_insert_lookup_unit.sv
verif/tb_array_bst_insert_lookup_unit.sv
